/* design/cfb_pkg.sv */
package cfb_pkg;

  // Default screen geometry.
  localparam int SCREEN_W_DEF = 128;
  localparam int SCREEN_H_DEF = 128;

  // Field widths fixed by the item format.
  localparam int KIND_W  = 2;
  localparam int CRD_W   = 16;
  localparam int COLOR_W = 8;
  localparam int CLIP_W  = 7;
  localparam int IDX_W   = 2;
  localparam int IN_DATA_W  = 4 * CRD_W + COLOR_W;
  localparam int OUT_DATA_W = COLOR_W;

  // Command codes carried in the input tuser.
  typedef enum logic [KIND_W-1:0] {
    KIND_CLEAR = 2'd0,
    KIND_SET   = 2'd1,
    KIND_GET   = 2'd2,
    KIND_FILL  = 2'd3
  } kind_t;

  // Configuration register indexes.
  typedef enum logic [IDX_W-1:0] {
    REG_CLIP_LEFT   = 2'd0,
    REG_CLIP_TOP    = 2'd1,
    REG_CLIP_RIGHT  = 2'd2,
    REG_CLIP_BOTTOM = 2'd3
  } reg_idx_t;

  localparam logic [CLIP_W-1:0] CLIP_LEFT_RST   = 7'd0;
  localparam logic [CLIP_W-1:0] CLIP_TOP_RST    = 7'd0;
  localparam logic [CLIP_W-1:0] CLIP_RIGHT_RST  = 7'd127;
  localparam logic [CLIP_W-1:0] CLIP_BOTTOM_RST = 7'd127;

  // Coordinates are compared one bit wider than the input so that clip
  // values and sign-extended inputs share one signed domain.
  typedef logic signed [CRD_W:0] crd_t;

  // Clip register limited to the last column or row of the screen.
  function automatic crd_t clip_cap(input logic [CLIP_W-1:0] r, input crd_t last);
    crd_t v;
    v = crd_t'({{(CRD_W + 1 - CLIP_W){1'b0}}, r});
    return (v > last) ? last : v;
  endfunction

endpackage

/* design/cfb_ram.sv */
module cfb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16384
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* design/clipped_framebuffer_fill_engine.sv */
// Channel   Direction  Handshake                Payload
// in_       slave      in_tvalid / in_tready    tuser: kind; tdata: x_a, y_a, x_b, y_b, color
// out_      master     out_tvalid / out_tready  tdata: read_color
// cfg_      slave      cfg_valid / cfg_ready    cfg_index, cfg_data (clip registers)
//
// After reset the pixel store is swept to zero, one pixel a cycle, over all
// SCREEN_W*SCREEN_H pixels; no item is taken during the sweep.
// One item is worked at a time. In S_DECODE a set writes its pixel and a get starts
// its read, finished in S_READ (skipped off screen); a fill passes S_FSETUP and
// writes one clipped pixel a cycle in S_FILL (neither if clipping leaves nothing),
// a clear the whole screen likewise in S_CLEAR: the pixel memory has one write port.
// A stalled result sits in the output register while the next item is taken;
// that item finishes only once the register is free.
module clipped_framebuffer_fill_engine #(
  parameter int SCREEN_W = cfb_pkg::SCREEN_W_DEF,
  parameter int SCREEN_H = cfb_pkg::SCREEN_H_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // Command input.
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // tdata from bit 0 up: x_a[15:0], y_a[15:0], x_b[15:0], y_b[15:0], color[7:0]
  input  logic [cfb_pkg::IN_DATA_W-1:0]    in_tdata,
  // tuser: kind[1:0]
  input  logic [cfb_pkg::KIND_W-1:0]       in_tuser,
  // Result output.
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // tdata from bit 0 up: read_color[7:0]
  output logic [cfb_pkg::OUT_DATA_W-1:0]   out_tdata,
  // Configuration writes.
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [cfb_pkg::IDX_W-1:0]        cfg_index,
  input  logic [cfb_pkg::CLIP_W-1:0]       cfg_data
);

  import cfb_pkg::*;

  localparam int XW    = $clog2(SCREEN_W);
  localparam int YW    = $clog2(SCREEN_H);
  localparam int DEPTH = SCREEN_W * SCREEN_H;
  localparam int AW    = $clog2(DEPTH);
  localparam crd_t XLAST = crd_t'(SCREEN_W - 1);
  localparam crd_t YLAST = crd_t'(SCREEN_H - 1);
  localparam logic [AW-1:0] ROW_STEP = AW'(SCREEN_W);
  localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

  // One-hot sequencer states.
  typedef enum logic [7:0] {
    S_INIT   = 8'b0000_0001,
    S_IDLE   = 8'b0000_0010,
    S_DECODE = 8'b0000_0100,
    S_CLEAR  = 8'b0000_1000,
    S_READ   = 8'b0001_0000,
    S_FSETUP = 8'b0010_0000,
    S_FILL   = 8'b0100_0000,
    S_RESP   = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;

  // Clip registers.
  logic [CLIP_W-1:0] clip_left_r, clip_top_r, clip_right_r, clip_bottom_r;

  // Captured command.
  kind_t               kind_r;
  logic [CRD_W-1:0]    xa_r, ya_r, xb_r, yb_r;
  logic [COLOR_W-1:0]  color_r;

  // Sweep counter, fill walkers and result.
  logic [AW-1:0]      cnt_r, cnt_nxt;
  logic [AW-1:0]      row_r, row_nxt;
  logic [XW-1:0]      x_r, x_nxt, lx_r, lx_nxt, hx_r, hx_nxt;
  logic [YW-1:0]      y_r, y_nxt, ly_r, ly_nxt, hy_r, hy_nxt;
  logic [COLOR_W-1:0] res_r, res_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [COLOR_W-1:0] out_data_r, out_data_nxt;

  // Memory port signals.
  logic               mem_we, mem_re;
  logic [AW-1:0]      mem_waddr;
  logic [COLOR_W-1:0] mem_wdata, mem_rdata;
  logic [AW-1:0]      pix_addr;

  // Decode values.
  crd_t cl, ct, cr, cb;
  crd_t xa, ya, xb, yb;
  crd_t lx_c, hx_c, ly_c, hy_c;
  logic set_ok, get_ok, fill_ok;

  assign in_tready  = (state_r == S_IDLE);
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  cfb_ram #(
    .WIDTH (COLOR_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (pix_addr),
    .rdata (mem_rdata)
  );

  // Clip bounds limited to the screen, and the command's coordinates
  // sign-extended into the compare domain.
  always_comb begin
    cl = clip_cap(clip_left_r, XLAST);
    ct = clip_cap(clip_top_r, YLAST);
    cr = clip_cap(clip_right_r, XLAST);
    cb = clip_cap(clip_bottom_r, YLAST);
    xa = {xa_r[CRD_W-1], xa_r};
    ya = {ya_r[CRD_W-1], ya_r};
    xb = {xb_r[CRD_W-1], xb_r};
    yb = {yb_r[CRD_W-1], yb_r};

    // The clip rectangle always lies on screen, so lying inside it implies
    // lying on screen. An empty clip fails one of the compares by itself.
    set_ok = (xa >= cl) && (xa <= cr) && (ya >= ct) && (ya <= cb);
    get_ok = !xa[CRD_W] && (xa <= XLAST) && !ya[CRD_W] && (ya <= YLAST);

    // Order the corners, then intersect with the clip rectangle.
    lx_c = (xa < xb) ? xa : xb;
    hx_c = (xa < xb) ? xb : xa;
    ly_c = (ya < yb) ? ya : yb;
    hy_c = (ya < yb) ? yb : ya;
    if (lx_c < cl) lx_c = cl;
    if (ly_c < ct) ly_c = ct;
    if (hx_c > cr) hx_c = cr;
    if (hy_c > cb) hy_c = cb;
    fill_ok = (lx_c <= hx_c) && (ly_c <= hy_c);

    pix_addr = AW'(AW'(ya_r[YW-1:0]) * ROW_STEP) + AW'(xa_r[XW-1:0]);
  end

  // Sequencer and memory control.
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    row_nxt       = row_r;
    x_nxt         = x_r;
    y_nxt         = y_r;
    lx_nxt        = lx_r;
    hx_nxt        = hx_r;
    ly_nxt        = ly_r;
    hy_nxt        = hy_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    mem_we        = 1'b0;
    mem_waddr     = cnt_r;
    mem_wdata     = color_r;
    mem_re        = 1'b0;

    case (state_r)
      S_INIT: begin
        // Zero the store after reset.
        mem_we    = 1'b1;
        mem_wdata = '0;
        cnt_nxt   = cnt_r + 1'b1;
        if (cnt_r == LAST_ADDR) begin
          cnt_nxt   = '0;
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_tvalid) begin
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        res_nxt = '0;
        case (kind_r)
          KIND_CLEAR: begin
            cnt_nxt   = '0;
            state_nxt = S_CLEAR;
          end
          KIND_SET: begin
            mem_we    = set_ok;
            mem_waddr = pix_addr;
            state_nxt = S_RESP;
          end
          KIND_GET: begin
            mem_re    = get_ok;
            state_nxt = get_ok ? S_READ : S_RESP;
          end
          KIND_FILL: begin
            lx_nxt    = lx_c[XW-1:0];
            hx_nxt    = hx_c[XW-1:0];
            ly_nxt    = ly_c[YW-1:0];
            hy_nxt    = hy_c[YW-1:0];
            state_nxt = fill_ok ? S_FSETUP : S_RESP;
          end
          default: begin
            state_nxt = S_RESP;
          end
        endcase
      end
      S_CLEAR: begin
        mem_we  = 1'b1;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == LAST_ADDR) begin
          state_nxt = S_RESP;
        end
      end
      S_READ: begin
        res_nxt   = mem_rdata;
        state_nxt = S_RESP;
      end
      S_FSETUP: begin
        row_nxt   = AW'(AW'(ly_r) * ROW_STEP);
        x_nxt     = lx_r;
        y_nxt     = ly_r;
        state_nxt = S_FILL;
      end
      S_FILL: begin
        // Walk the clipped rectangle row by row, one pixel a cycle.
        mem_we    = 1'b1;
        mem_waddr = row_r + AW'(x_r);
        if (x_r == hx_r) begin
          x_nxt = lx_r;
          if (y_r == hy_r) begin
            state_nxt = S_RESP;
          end else begin
            y_nxt   = y_r + 1'b1;
            row_nxt = row_r + ROW_STEP;
          end
        end else begin
          x_nxt = x_r + 1'b1;
        end
      end
      S_RESP: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = res_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_INIT;
      cnt_r         <= '0;
      out_valid_r   <= 1'b0;
      clip_left_r   <= CLIP_LEFT_RST;
      clip_top_r    <= CLIP_TOP_RST;
      clip_right_r  <= CLIP_RIGHT_RST;
      clip_bottom_r <= CLIP_BOTTOM_RST;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_CLIP_LEFT:   clip_left_r   <= cfg_data;
          REG_CLIP_TOP:    clip_top_r    <= cfg_data;
          REG_CLIP_RIGHT:  clip_right_r  <= cfg_data;
          REG_CLIP_BOTTOM: clip_bottom_r <= cfg_data;
          default: begin
          end
        endcase
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      kind_r  <= kind_t'(in_tuser);
      xa_r    <= in_tdata[CRD_W-1:0];
      ya_r    <= in_tdata[2*CRD_W-1:CRD_W];
      xb_r    <= in_tdata[3*CRD_W-1:2*CRD_W];
      yb_r    <= in_tdata[4*CRD_W-1:3*CRD_W];
      color_r <= in_tdata[4*CRD_W+COLOR_W-1:4*CRD_W];
    end
    row_r      <= row_nxt;
    x_r        <= x_nxt;
    y_r        <= y_nxt;
    lx_r       <= lx_nxt;
    hx_r       <= hx_nxt;
    ly_r       <= ly_nxt;
    hy_r       <= hy_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

/* test/tb_clipped_framebuffer_fill_engine.sv */
module tb_clipped_framebuffer_fill_engine;
  timeunit 1ns;
  timeprecision 1ps;

  import cfb_pkg::*;

  localparam int SCREEN_W = SCREEN_W_DEF;
  localparam int SCREEN_H = SCREEN_H_DEF;
  localparam int SCREEN_PIXELS = SCREEN_W * SCREEN_H;

  // The receiver holds off this long, twice per run, so that the output
  // register fills, the engine takes one more item and then stalls its input.
  localparam int LONG_HOLD_CYCLES = 400;
  // Cycles to watch for stray results once everything expected has arrived.
  localparam int DRAIN_CYCLES = 40;
  localparam int RANDOM_PHASES = 11;
  localparam int ITEMS_PER_PHASE = 86;

  // One drawing command as it travels on the input channel.
  typedef struct packed {
    kind_t              kind;
    logic signed [15:0] xa;
    logic signed [15:0] ya;
    logic signed [15:0] xb;
    logic signed [15:0] yb;
    logic [7:0]         color;
  } fb_cmd_t;

  // Shadow copy of the screen store and clip registers. Every accepted
  // command is applied here in acceptance order, and the color that it
  // should return is queued for comparison with the result channel.
  class framebuffer_shadow;
    logic [7:0]        pixels[SCREEN_PIXELS];
    logic [CLIP_W-1:0] clip_reg[4];
    logic [7:0]        expected_colors[$];
    int                errors;

    function new();
      foreach (pixels[i]) pixels[i] = 8'h00;
      clip_reg[REG_CLIP_LEFT]   = CLIP_LEFT_RST;
      clip_reg[REG_CLIP_TOP]    = CLIP_TOP_RST;
      clip_reg[REG_CLIP_RIGHT]  = CLIP_RIGHT_RST;
      clip_reg[REG_CLIP_BOTTOM] = CLIP_BOTTOM_RST;
      errors = 0;
    endfunction

    function void write_clip(reg_idx_t idx, logic [CLIP_W-1:0] value);
      clip_reg[idx] = value;
    endfunction

    // A clip register past the screen edge acts as the last column or row.
    function int clip_limit(reg_idx_t idx, int last);
      int v;
      v = int'(clip_reg[idx]);
      return (v > last) ? last : v;
    endfunction

    function bit on_screen(int x, int y);
      return x >= 0 && x < SCREEN_W && y >= 0 && y < SCREEN_H;
    endfunction

    function void note_command(fb_cmd_t c);
      int xa, ya, xb, yb;
      int cl, ct, cr, cb;
      int lx, hx, ly, hy;
      logic [7:0] read_color;
      xa = int'(c.xa);
      ya = int'(c.ya);
      xb = int'(c.xb);
      yb = int'(c.yb);
      cl = clip_limit(REG_CLIP_LEFT, SCREEN_W - 1);
      ct = clip_limit(REG_CLIP_TOP, SCREEN_H - 1);
      cr = clip_limit(REG_CLIP_RIGHT, SCREEN_W - 1);
      cb = clip_limit(REG_CLIP_BOTTOM, SCREEN_H - 1);
      read_color = 8'h00;
      case (c.kind)
        KIND_CLEAR: begin
          foreach (pixels[i]) pixels[i] = c.color;
        end
        KIND_SET: begin
          if (on_screen(xa, ya) && xa >= cl && xa <= cr && ya >= ct && ya <= cb)
            pixels[ya * SCREEN_W + xa] = c.color;
        end
        KIND_GET: begin
          if (on_screen(xa, ya))
            read_color = pixels[ya * SCREEN_W + xa];
        end
        default: begin
          lx = (xa < xb) ? xa : xb;
          hx = (xa < xb) ? xb : xa;
          ly = (ya < yb) ? ya : yb;
          hy = (ya < yb) ? yb : ya;
          if (lx < cl) lx = cl;
          if (ly < ct) ly = ct;
          if (hx > cr) hx = cr;
          if (hy > cb) hy = cb;
          for (int y = ly; y <= hy; y++)
            for (int x = lx; x <= hx; x++)
              pixels[y * SCREEN_W + x] = c.color;
        end
      endcase
      expected_colors.push_back(read_color);
    endfunction

    function void check_read_color(logic [7:0] actual);
      logic [7:0] wanted;
      if (expected_colors.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual read_color %02h",
                 $time, actual);
        errors++;
      end else begin
        wanted = expected_colors.pop_front();
        if (actual !== wanted) begin
          $display("%0t: read_color mismatch, expected %02h, actual %02h",
                   $time, wanted, actual);
          errors++;
        end
      end
    endfunction

    function int pending();
      return expected_colors.size();
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic [KIND_W-1:0]     in_tuser;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [IDX_W-1:0]      cfg_index;
  logic [CLIP_W-1:0]     cfg_data;

  framebuffer_shadow board;

  // Idling controls shared by the sender and the receiver. Each phase picks
  // its own, so some stretches run back to back; the tail has no idling.
  bit feed_idles;
  bit sink_idles;
  bit quiet_tail;
  int results_taken;

  clipped_framebuffer_fill_engine #(
    .SCREEN_W(SCREEN_W),
    .SCREEN_H(SCREEN_H)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // A generous ceiling: the reset sweep, a handful of full-screen clears and
  // fills, the long hold-offs and all random stalls fit many times over.
  initial begin
    #40_000_000;
    $display("status: fail");
    $finish;
  end

  // Every result is compared with the oldest outstanding expectation at the
  // edge where it is taken.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      board.check_read_color(out_tdata);
      results_taken++;
    end
  end

  // Receiver. Inputs change only on the falling edge. Two long hold-offs are
  // triggered by the number of results taken so far; otherwise out_tready
  // drops in short random bursts while the phase allows it.
  initial begin
    int long_hold_mark;
    out_tready = 1'b0;
    long_hold_mark = 150;
    forever begin
      @(negedge clk);
      if (rst_n && results_taken >= long_hold_mark) begin
        long_hold_mark = (long_hold_mark == 150) ? 600 : 32'h7fff_ffff;
        out_tready <= 1'b0;
        repeat (LONG_HOLD_CYCLES - 1) @(negedge clk);
      end else if (!quiet_tail && sink_idles && $urandom_range(0, 4) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(0, 6)) @(negedge clk);
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  function automatic fb_cmd_t compose(kind_t kind, int xa, int ya, int xb, int yb,
                                      int color);
    fb_cmd_t c;
    c.kind  = kind;
    c.xa    = 16'(xa);
    c.ya    = 16'(ya);
    c.xb    = 16'(xb);
    c.yb    = 16'(yb);
    c.color = 8'(color);
    return c;
  endfunction

  // Mostly on screen, sometimes just past an edge, sometimes anywhere in the
  // 16-bit range so that every coordinate bit, the sign included, toggles.
  function automatic int rand_coord();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0)
      return int'($signed(16'($urandom)));
    else if (r == 1)
      return ($urandom_range(0, 1) == 0) ? -int'($urandom_range(1, 8))
                                         : 127 + int'($urandom_range(1, 8));
    else
      return int'($urandom_range(0, 127));
  endfunction

  function automatic fb_cmd_t random_command();
    int r, xa, ya;
    r = $urandom_range(0, 199);
    if (r == 0)
      return compose(KIND_CLEAR, $urandom, $urandom, $urandom, $urandom, $urandom);
    if (r <= 50) begin
      // A few fills span the whole 16-bit range; the rest are small
      // rectangles near the screen so that the run stays short.
      if ($urandom_range(0, 24) == 0)
        return compose(KIND_FILL, $urandom, $urandom, $urandom, $urandom, $urandom);
      xa = int'($urandom_range(0, 135)) - 4;
      ya = int'($urandom_range(0, 135)) - 4;
      return compose(KIND_FILL, xa, ya, xa + int'($urandom_range(0, 24)) - 12,
                     ya + int'($urandom_range(0, 24)) - 12, $urandom);
    end
    if (r <= 125)
      return compose(KIND_SET, rand_coord(), rand_coord(), $urandom, $urandom, $urandom);
    return compose(KIND_GET, rand_coord(), rand_coord(), $urandom, $urandom, $urandom);
  endfunction

  // Offers one item and returns on the falling edge after it was taken.
  // tvalid is left high so that back-to-back items need no extra edge.
  task automatic issue_command(fb_cmd_t c);
    if (!quiet_tail && feed_idles && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= c.kind;
    in_tdata  <= {c.color, c.yb, c.xb, c.ya, c.xa};
    do @(posedge clk); while (!in_tready);
    board.note_command(c);
    @(negedge clk);
  endtask

  // The sender pauses until every expected result has come back.
  task automatic wait_for_drain();
    in_tvalid <= 1'b0;
    while (board.pending() != 0) @(negedge clk);
  endtask

  task automatic write_clip_reg(reg_idx_t idx, int value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= CLIP_W'(value);
    do @(posedge clk); while (!cfg_ready);
    board.write_clip(idx, CLIP_W'(value));
    @(negedge clk);
  endtask

  // The clip rectangle changes only while the engine is idle.
  task automatic set_clip(int left, int top, int right, int bottom);
    wait_for_drain();
    write_clip_reg(REG_CLIP_LEFT, left);
    write_clip_reg(REG_CLIP_TOP, top);
    write_clip_reg(REG_CLIP_RIGHT, right);
    write_clip_reg(REG_CLIP_BOTTOM, bottom);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    int l, t, r, b, swap;
    board = new();
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = KIND_CLEAR;
    cfg_valid = 1'b0;
    cfg_index = REG_CLIP_LEFT;
    cfg_data = '0;
    feed_idles = 1'b1;
    sink_idles = 1'b1;
    quiet_tail = 1'b0;
    results_taken = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed part under the full-screen clip, written explicitly even
    // though it matches the reset values. The store starts out all zero.
    set_clip(0, 0, 127, 127);
    issue_command(compose(KIND_GET, 0, 0, 0, 0, 0));
    // Corner pixels, with junk in the unused second corner.
    issue_command(compose(KIND_SET, 0, 0, 16'h8000, 16'h7fff, 8'hff));
    issue_command(compose(KIND_SET, 127, 127, 16'hffff, 0, 8'h01));
    // Points just off the left and right edges and at the coordinate extremes write nothing.
    issue_command(compose(KIND_SET, -1, 5, 0, 0, 8'haa));
    issue_command(compose(KIND_SET, 128, 5, 0, 0, 8'haa));
    issue_command(compose(KIND_SET, 5, -32768, 0, 0, 8'haa));
    issue_command(compose(KIND_SET, 32767, 32767, 0, 0, 8'haa));
    // Reads ignore the color field; off-screen reads return zero.
    issue_command(compose(KIND_GET, 0, 0, 16'h1234, 16'h8765, 8'h5a));
    issue_command(compose(KIND_GET, 127, 127, 0, 0, 8'hff));
    issue_command(compose(KIND_GET, 128, 5, 0, 0, 0));
    issue_command(compose(KIND_GET, -32768, -1, 0, 0, 0));
    // Fill with the corners given high-to-low in both directions.
    issue_command(compose(KIND_FILL, 20, 30, 10, 25, 8'h3c));
    issue_command(compose(KIND_GET, 15, 27, 0, 0, 0));
    // Fills that lie fully outside the screen change nothing.
    issue_command(compose(KIND_FILL, -50, -50, -1, -1, 8'hee));
    issue_command(compose(KIND_FILL, 128, 0, 32767, 127, 8'hee));
    // Fill from the most negative to the most positive corner covers it all.
    issue_command(compose(KIND_FILL, -32768, -32768, 32767, 32767, 8'h81));
    issue_command(compose(KIND_GET, 64, 64, 0, 0, 0));
    // Clear ignores every coordinate.
    issue_command(compose(KIND_CLEAR, 16'h8001, 16'h7ffe, 16'hc3c3, 16'h3c3c, 8'ha5));
    issue_command(compose(KIND_GET, 127, 0, 0, 0, 0));

    // An empty clip rectangle blocks both set and fill, but not get.
    set_clip(100, 0, 20, 127);
    issue_command(compose(KIND_SET, 50, 50, 0, 0, 8'h11));
    issue_command(compose(KIND_FILL, 0, 0, 127, 127, 8'h22));
    issue_command(compose(KIND_GET, 50, 50, 0, 0, 0));

    // Random phases: a few fixed clip shapes at the extremes, then random
    // ones, mostly well formed with the occasional inverted edge pair.
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      case (phase)
        0: begin l = 0;   t = 0;   r = 127; b = 127; end
        1: begin l = 64;  t = 64;  r = 64;  b = 64;  end
        2: begin l = 0;   t = 90;  r = 127; b = 30;  end
        3: begin l = 127; t = 127; r = 127; b = 127; end
        default: begin
          l = $urandom_range(0, 127);
          r = $urandom_range(0, 127);
          t = $urandom_range(0, 127);
          b = $urandom_range(0, 127);
          if (l > r && $urandom_range(0, 3) != 0) begin
            swap = l; l = r; r = swap;
          end
          if (t > b && $urandom_range(0, 3) != 0) begin
            swap = t; t = b; b = swap;
          end
        end
      endcase
      set_clip(l, t, r, b);
      feed_idles = (phase == 0) || ($urandom_range(0, 3) != 0);
      sink_idles = (phase == 0) || ($urandom_range(0, 3) != 0);
      quiet_tail = (phase == RANDOM_PHASES - 1);
      for (int n = 0; n < ITEMS_PER_PHASE; n++)
        issue_command(random_command());
    end

    wait_for_drain();
    // Watch a little longer for any result that nobody asked for.
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (board.errors == 0 && board.pending() == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule
